// ----- rtl/gmd_pkg.sv -----
// shared types, constants and saturation helper for the gamut map desaturation block
package gmd_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int FRACTION_BITS = 16;
    localparam int WEIGHT_WIDTH  = 17;
    localparam int LANES         = 3;
    localparam int DIV_NW        = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int DIV_DW        = SAMPLE_WIDTH;
    localparam int PROD_WIDTH    = SAMPLE_WIDTH + WEIGHT_WIDTH + 1;

    localparam longint SMAX_L = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SMIN_L = -(longint'(1) << (SAMPLE_WIDTH - 1));
    localparam longint ONE_L  = longint'(1) << FRACTION_BITS;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [WEIGHT_WIDTH-1:0] weight_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;

    localparam sample_t SMAX_S = SAMPLE_WIDTH'(SMAX_L);
    localparam sample_t SMIN_S = SAMPLE_WIDTH'(SMIN_L);
    localparam sample_t ONE_S  = SAMPLE_WIDTH'(ONE_L);

    localparam weight_t RESET_LUMA_RED   = WEIGHT_WIDTH'(13933);
    localparam weight_t RESET_LUMA_GREEN = WEIGHT_WIDTH'(46871);
    localparam weight_t RESET_LUMA_BLUE  = WEIGHT_WIDTH'(4732);
    localparam weight_t RESET_SAT_MIX    = WEIGHT_WIDTH'(0);

    typedef enum logic [1:0] {
        CFG_LUMA_RED,
        CFG_LUMA_GREEN,
        CFG_LUMA_BLUE,
        CFG_SAT_MIX
    } cfg_index_t;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
    } pixel_t;

    typedef struct packed {
        sample_t              y;
        sample_t [LANES-1:0]  ch;
        logic    [LANES-1:0]  dneg;
        logic    [LANES-1:0]  dzero;
    } div_side_t;

    function automatic sample_t sat_s(input logic signed [63:0] v);
        sample_t r;
        if (v > SMAX_L)
            r = SMAX_S;
        else if (v < SMIN_L)
            r = SMIN_S;
        else
            r = SAMPLE_WIDTH'(v);
        return r;
    endfunction

endpackage

// ----- rtl/gmd_div.sv -----
// pipelined restoring divider, three lanes, one quotient bit per stage, saturated signed result
module gmd_div import gmd_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NW-1:0]    num_mag [LANES],
    input  logic [DIV_DW-1:0]    den_mag [LANES],
    input  logic                 neg [LANES],
    output sample_t              quot [LANES]
);

    localparam logic [DIV_NW-1:0] POS_LIM = DIV_NW'(SMAX_L);
    localparam logic [DIV_NW-1:0] NEG_LIM = DIV_NW'(-SMIN_L);

    logic [DIV_DW-1:0] rem_reg [DIV_NW][LANES];
    logic [DIV_NW-1:0] num_reg [DIV_NW][LANES];
    logic [DIV_NW-1:0] quo_reg [DIV_NW][LANES];
    logic [DIV_DW-1:0] den_reg [DIV_NW][LANES];
    logic              neg_reg [DIV_NW][LANES];

    logic [DIV_DW-1:0] rem_next [DIV_NW][LANES];
    logic [DIV_NW-1:0] num_next [DIV_NW][LANES];
    logic [DIV_NW-1:0] quo_next [DIV_NW][LANES];
    logic [DIV_DW-1:0] den_next [DIV_NW][LANES];
    logic              neg_next [DIV_NW][LANES];

    always_comb
    begin
        for (int s = 0; s < DIV_NW; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [DIV_DW-1:0] prem;
                logic [DIV_NW-1:0] pnum;
                logic [DIV_NW-1:0] pquo;
                logic [DIV_DW:0]   trial;
                logic              qbit;
                if (s == 0)
                begin
                    prem = '0;
                    pnum = num_mag[l];
                    pquo = '0;
                    den_next[s][l] = den_mag[l];
                    neg_next[s][l] = neg[l];
                end
                else
                begin
                    prem = rem_reg[s-1][l];
                    pnum = num_reg[s-1][l];
                    pquo = quo_reg[s-1][l];
                    den_next[s][l] = den_reg[s-1][l];
                    neg_next[s][l] = neg_reg[s-1][l];
                end
                trial = {prem, pnum[DIV_NW-1]};
                qbit = (trial >= {1'b0, den_next[s][l]});
                if (qbit)
                    trial = trial - {1'b0, den_next[s][l]};
                rem_next[s][l] = trial[DIV_DW-1:0];
                num_next[s][l] = {pnum[DIV_NW-2:0], 1'b0};
                quo_next[s][l] = {pquo[DIV_NW-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
            den_reg <= den_next;
            neg_reg <= neg_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [DIV_NW-1:0] q;
            q = quo_reg[DIV_NW-1][l];
            if (neg_reg[DIV_NW-1][l])
            begin
                if (q > NEG_LIM)
                    quot[l] = SMIN_S;
                else
                    quot[l] = SAMPLE_WIDTH'(-q);
            end
            else
            begin
                if (q > POS_LIM)
                    quot[l] = SMAX_S;
                else
                    quot[l] = SAMPLE_WIDTH'(q);
            end
        end
    end

endmodule

// ----- rtl/rgb_gamut_map_desaturate_top.sv -----
// top level of the luminance preserving gamut map desaturation pipeline
// usage:
// - in_valid/in_stall/in_data carry one rgb word per accepted cycle
// - out_valid/out_stall/out_data return one mapped rgb word per input word
// - cfg_valid/cfg_ready/cfg_index/cfg_data write the luma weights and the
//   saturation mix; cfg_ready is always high, write only while idle
// - the pipeline runs through the luma product and luma registers, the gray
//   weight divider, the blend and mix registers, the normalize divider and
//   one output register
// - throughput is one word per cycle when not stalled, via pipelined dividers
// - in_stall rises only while a result sits in the output register and
//   out_stall is high; the whole pipeline then holds, nothing is lost
// - reset clears all valid bits and loads the default weights
module rgb_gamut_map_desaturate_top import gmd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pixel_t      in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output pixel_t      out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  weight_t     cfg_data
);

    weight_t luma_red_reg, luma_green_reg, luma_blue_reg, sat_mix_reg;
    logic    en;
    logic    out_valid_reg;
    pixel_t  out_data_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_red_reg   <= RESET_LUMA_RED;
            luma_green_reg <= RESET_LUMA_GREEN;
            luma_blue_reg  <= RESET_LUMA_BLUE;
            sat_mix_reg    <= RESET_SAT_MIX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LUMA_RED:   luma_red_reg   <= cfg_data;
                CFG_LUMA_GREEN: luma_green_reg <= cfg_data;
                CFG_LUMA_BLUE:  luma_blue_reg  <= cfg_data;
                CFG_SAT_MIX:    sat_mix_reg    <= cfg_data;
            endcase
        end
    end

    // valid bits
    logic v1_reg, v2_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic d1v_reg [DIV_NW];
    logic d2v_reg [DIV_NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_NW; s++)
            begin
                d1v_reg[s] <= 1'b0;
                d2v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            d1v_reg[0] <= v2_reg;
            for (int s = 1; s < DIV_NW; s++)
                d1v_reg[s] <= d1v_reg[s-1];
            v4_reg <= d1v_reg[DIV_NW-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            d2v_reg[0] <= v7_reg;
            for (int s = 1; s < DIV_NW; s++)
                d2v_reg[s] <= d2v_reg[s-1];
            out_valid_reg <= d2v_reg[DIV_NW-1];
        end
    end

    // stage 1: luma products
    sample_t in_ch [LANES];
    weight_t wt [LANES];
    sample_t ch1_reg [LANES];
    prod_t   prod1_reg [LANES];

    assign in_ch[0] = in_data.red;
    assign in_ch[1] = in_data.green;
    assign in_ch[2] = in_data.blue;
    assign wt[0] = luma_red_reg;
    assign wt[1] = luma_green_reg;
    assign wt[2] = luma_blue_reg;

    // stage 2: luma
    sample_t ch2_reg [LANES];
    sample_t y2_reg;

    // gray weight divider inputs
    logic [DIV_NW-1:0] d1_num [LANES];
    logic [DIV_DW-1:0] d1_den [LANES];
    logic              d1_neg [LANES];
    sample_t           d1_q [LANES];
    div_side_t         side_in;
    div_side_t         side_reg [DIV_NW];
    div_side_t         side_out;

    always_comb
    begin
        side_in.y = y2_reg;
        for (int i = 0; i < LANES; i++)
        begin
            sample_t d;
            sample_t n;
            logic [SAMPLE_WIDTH-1:0] nmag;
            d = sat_s(ch2_reg[i] - y2_reg);
            if (d < 0)
                n = ch2_reg[i];
            else
                n = sat_s(ch2_reg[i] - ONE_L);
            if (n == SMIN_S)
                n = -SMAX_S;
            nmag = (n < 0) ? SAMPLE_WIDTH'(-n) : n;
            d1_num[i] = {nmag, {FRACTION_BITS{1'b0}}};
            if (d == 0)
                d1_den[i] = DIV_DW'(1);
            else
                d1_den[i] = (d < 0) ? DIV_DW'(-d) : d;
            d1_neg[i] = (n < 0) ^ (d < 0);
            side_in.ch[i]    = ch2_reg[i];
            side_in.dneg[i]  = (d < 0);
            side_in.dzero[i] = (d == 0);
        end
    end

    gmd_div u_div_gray (
        .clk     (clk),
        .en      (en),
        .num_mag (d1_num),
        .den_mag (d1_den),
        .neg     (d1_neg),
        .quot    (d1_q)
    );

    assign side_out = side_reg[DIV_NW-1];

    // stage 4: gray weights
    sample_t ch4_reg [LANES];
    sample_t y4_reg, gsat4_reg, glum4_reg;
    sample_t gsat_c, glum_c;

    always_comb
    begin
        gsat_c = '0;
        glum_c = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sample_t gl;
            if (side_out.dneg[i] && d1_q[i] > gsat_c)
                gsat_c = d1_q[i];
            if (side_out.dneg[i] || side_out.dzero[i])
                gl = gsat_c;
            else
                gl = d1_q[i];
            if (gl > glum_c)
                glum_c = gl;
        end
    end

    // stage 5 to 7
    sample_t ch5_reg [LANES];
    sample_t y5_reg, glum5_reg;
    prod_t   prod5_reg;
    sample_t gdiff;
    sample_t ch6_reg [LANES];
    sample_t y6_reg;
    logic [FRACTION_BITS:0] gmix6_reg;
    sample_t gmix_c;
    sample_t ch7_reg [LANES];
    prod_t   prod7_reg [LANES];

    assign gdiff  = sat_s(gsat4_reg - glum4_reg);
    assign gmix_c = sat_s((prod5_reg >>> FRACTION_BITS) + glum5_reg);

    // stage 8: mixed channels into normalize divider
    logic [DIV_NW-1:0] d2_num [LANES];
    logic [DIV_DW-1:0] d2_den [LANES];
    logic              d2_neg [LANES];
    sample_t           d2_q [LANES];

    always_comb
    begin
        sample_t mixed [LANES];
        sample_t mx;
        mx = ONE_S;
        for (int i = 0; i < LANES; i++)
        begin
            mixed[i] = sat_s(ch7_reg[i] + (prod7_reg[i] >>> FRACTION_BITS));
            if (mixed[i] > mx)
                mx = mixed[i];
        end
        for (int i = 0; i < LANES; i++)
        begin
            logic [SAMPLE_WIDTH-1:0] mag;
            mag = (mixed[i] < 0) ? SAMPLE_WIDTH'(-mixed[i]) : mixed[i];
            d2_num[i] = {mag, {FRACTION_BITS{1'b0}}};
            d2_den[i] = mx;
            d2_neg[i] = (mixed[i] < 0);
        end
    end

    gmd_div u_div_norm (
        .clk     (clk),
        .en      (en),
        .num_mag (d2_num),
        .den_mag (d2_den),
        .neg     (d2_neg),
        .quot    (d2_q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ch1_reg[i]   <= in_ch[i];
                prod1_reg[i] <= in_ch[i] * $signed({1'b0, wt[i]});
                ch2_reg[i]   <= ch1_reg[i];
                ch4_reg[i]   <= side_out.ch[i];
                ch5_reg[i]   <= ch4_reg[i];
                ch6_reg[i]   <= ch5_reg[i];
                ch7_reg[i]   <= ch6_reg[i];
                prod7_reg[i] <= $signed({1'b0, gmix6_reg}) * sat_s(y6_reg - ch6_reg[i]);
            end
            y2_reg <= sat_s((prod1_reg[0] + prod1_reg[1] + prod1_reg[2]) >>> 16);
            side_reg[0] <= side_in;
            for (int s = 1; s < DIV_NW; s++)
                side_reg[s] <= side_reg[s-1];
            y4_reg    <= side_out.y;
            gsat4_reg <= gsat_c;
            glum4_reg <= glum_c;
            y5_reg    <= y4_reg;
            glum5_reg <= glum4_reg;
            prod5_reg <= gdiff * $signed({1'b0, sat_mix_reg});
            y6_reg    <= y5_reg;
            if (gmix_c > ONE_S)
                gmix6_reg <= (FRACTION_BITS + 1)'(ONE_L);
            else if (gmix_c < 0)
                gmix6_reg <= '0;
            else
                gmix6_reg <= (FRACTION_BITS + 1)'(gmix_c);
            out_data_reg.red   <= d2_q[0];
            out_data_reg.green <= d2_q[1];
            out_data_reg.blue  <= d2_q[2];
        end
    end

    a_out_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.red <= ONE_S) && (out_data.green <= ONE_S)
                      && (out_data.blue <= ONE_S))
        else $error("mapped word exceeds one");

    a_gmix_range: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> gmix6_reg <= (FRACTION_BITS + 1)'(ONE_L))
        else $error("gray mix weight out of range");

    a_gsat_positive: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (gsat4_reg >= 0) && (glum4_reg >= 0))
        else $error("gray weights negative");

endmodule

// ----- verif/rgb_gamut_map_desaturate_top_tb.sv -----
// self-checking testbench for the rgb gamut map desaturation pipeline
`timescale 1ns / 100ps

module rgb_gamut_map_desaturate_top_tb import gmd_pkg::*;;

    localparam int LATENCY = 87;
    localparam longint CYCLE_LIMIT = 400000;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    pixel_t  in_data;
    logic    out_valid;
    logic    out_stall;
    pixel_t  out_data;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [1:0] cfg_index;
    weight_t cfg_data;

    pixel_t  pending_pixels[$];
    pixel_t  mapped_pixels[$];
    longint  weight_red, weight_green, weight_blue, mix_weight;
    int      mismatches;
    int      words_checked;
    longint  cycle_count;
    int      send_gap;
    int      recv_gap;
    bit      hold_off;
    int      hold_cycles;

    rgb_gamut_map_desaturate_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip(longint v);
        if (v > SMAX_L)
            return SMAX_L;
        if (v < SMIN_L)
            return SMIN_L;
        return v;
    endfunction

    function automatic longint gray_quotient(longint num, longint den);
        longint n;
        n = num;
        if (n > SMAX_L)
            n = SMAX_L;
        if (n < -SMAX_L)
            n = -SMAX_L;
        return clip((n * ONE_L) / den);
    endfunction

    function automatic pixel_t desaturate(pixel_t px);
        longint c[3];
        longint mixed[3];
        longint y, gsat, glum, gl, d, gmix, peak;
        pixel_t r;
        c[0] = longint'(px.red);
        c[1] = longint'(px.green);
        c[2] = longint'(px.blue);
        y = clip((c[0] * weight_red + c[1] * weight_green + c[2] * weight_blue) >>> 16);
        gsat = 0;
        glum = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = clip(c[i] - y);
            if (d < 0 && gray_quotient(c[i], d) > gsat)
                gsat = gray_quotient(c[i], d);
            if (d <= 0)
                gl = gsat;
            else
                gl = gray_quotient(clip(c[i] - ONE_L), d);
            if (gl > glum)
                glum = gl;
        end
        gmix = clip((clip(gsat - glum) * mix_weight >>> 16) + glum);
        if (gmix > ONE_L)
            gmix = ONE_L;
        if (gmix < 0)
            gmix = 0;
        peak = ONE_L;
        for (int i = 0; i < 3; i++)
        begin
            mixed[i] = clip(c[i] + ((gmix * clip(y - c[i])) >>> FRACTION_BITS));
            if (mixed[i] > peak)
                peak = mixed[i];
        end
        r.red   = sample_t'(clip((mixed[0] * ONE_L) / peak));
        r.green = sample_t'(clip((mixed[1] * ONE_L) / peak));
        r.blue  = sample_t'(clip((mixed[2] * ONE_L) / peak));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch word %0d %s got %0d want %0d", words_checked, what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 5))
            0: return sample_t'($urandom);
            1: return sample_t'($urandom_range(0, 65536));
            2: return sample_t'($signed($urandom_range(0, 200000)) - 40000);
            3: return sample_t'($urandom_range(0, 1) ? SMAX_L : SMIN_L);
            default: return sample_t'($signed($urandom_range(0, 4 * 65536)) - 65536);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                mapped_pixels.push_back(desaturate(in_data));
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_pixels.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_pixels.pop_front();
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (mapped_pixels.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    pixel_t want;
                    want = mapped_pixels.pop_front();
                    if (out_data.red !== want.red)
                        report_mismatch("red", out_data.red, want.red);
                    if (out_data.green !== want.green)
                        report_mismatch("green", out_data.green, want.green);
                    if (out_data.blue !== want.blue)
                        report_mismatch("blue", out_data.blue, want.blue);
                end
                words_checked++;
            end
            if (hold_off)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                out_stall <= 1'b1;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                recv_gap  <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_off = 1'b0;
        hold_cycles = 0;
        wait (words_checked > 400);
        @(posedge clk);
        hold_off = 1'b1;
        while (hold_cycles < 300)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_off = 1'b0;
    end

    task automatic write_reg(cfg_index_t idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= weight_t'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LUMA_RED:   weight_red   = value;
            CFG_LUMA_GREEN: weight_green = value;
            CFG_LUMA_BLUE:  weight_blue  = value;
            CFG_SAT_MIX:    mix_weight   = value;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || in_valid || mapped_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic push_pixel(longint r, longint g, longint b);
        pixel_t px;
        px.red   = sample_t'(r);
        px.green = sample_t'(g);
        px.blue  = sample_t'(b);
        pending_pixels.push_back(px);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        words_checked = 0;
        cycle_count = 0;
        weight_red = RESET_LUMA_RED;
        weight_green = RESET_LUMA_GREEN;
        weight_blue = RESET_LUMA_BLUE;
        mix_weight = RESET_SAT_MIX;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: extremes, gray, in gamut, out of gamut
        push_pixel(0, 0, 0);
        push_pixel(ONE_L, ONE_L, ONE_L);
        push_pixel(SMAX_L, SMAX_L, SMAX_L);
        push_pixel(SMIN_L, SMIN_L, SMIN_L);
        push_pixel(SMAX_L, SMIN_L, 0);
        push_pixel(SMIN_L, SMAX_L, SMIN_L);
        push_pixel(-1, -1, -1);
        push_pixel(ONE_L, 0, 0);
        push_pixel(0, ONE_L, 0);
        push_pixel(0, 0, ONE_L);
        push_pixel(2 * ONE_L, ONE_L / 2, -ONE_L / 4);
        push_pixel(-ONE_L, 2 * ONE_L, ONE_L);
        push_pixel(ONE_L / 2, ONE_L / 2, 3 * ONE_L);
        push_pixel(SMAX_L, 0, 0);
        push_pixel(0, 0, SMIN_L);
        push_pixel(40000, 40000, 40000);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(CFG_SAT_MIX, 65536);
                1:
                begin
                    write_reg(CFG_LUMA_RED, 0);
                    write_reg(CFG_LUMA_GREEN, 0);
                    write_reg(CFG_LUMA_BLUE, 0);
                    write_reg(CFG_SAT_MIX, 32768);
                end
                2:
                begin
                    write_reg(CFG_LUMA_RED, 131071);
                    write_reg(CFG_LUMA_GREEN, 131071);
                    write_reg(CFG_LUMA_BLUE, 131071);
                    write_reg(CFG_SAT_MIX, 131071);
                end
                3:
                begin
                    write_reg(CFG_LUMA_RED, 65536);
                    write_reg(CFG_LUMA_GREEN, 0);
                    write_reg(CFG_LUMA_BLUE, 0);
                    write_reg(CFG_SAT_MIX, 0);
                end
                4:
                begin
                    write_reg(CFG_LUMA_RED, $urandom_range(0, 131071));
                    write_reg(CFG_LUMA_GREEN, $urandom_range(0, 131071));
                    write_reg(CFG_LUMA_BLUE, $urandom_range(0, 131071));
                    write_reg(CFG_SAT_MIX, $urandom_range(0, 131071));
                end
                default:
                begin
                    write_reg(CFG_LUMA_RED, 13933);
                    write_reg(CFG_LUMA_GREEN, 46871);
                    write_reg(CFG_LUMA_BLUE, 4732);
                    write_reg(CFG_SAT_MIX, $urandom_range(0, 65536));
                end
            endcase
            for (int n = 0; n < 300; n++)
            begin
                pixel_t px;
                px.red   = random_sample();
                px.green = random_sample();
                px.blue  = random_sample();
                pending_pixels.push_back(px);
            end
            wait_drained();
        end

        $display("checked %0d mapped words over seven weight settings", words_checked);
        $display("settings included zero, unity and full-scale weights and a long output stall");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
